// ===== rtl/mbps_pkg.sv =====
// Shared constants, types and colour weights for the metaball pixel shader.
`default_nettype none

package mbps_pkg;

    // Fixed field widths
    localparam int PIX_W     = 8;
    localparam int CX_W      = 10;
    localparam int CY_W      = 9;
    localparam int CHAN_W    = 8;
    localparam int RGB_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CIRCLE_MAX = 4;

    // Register map
    localparam int CFG_X_BASE = 0;
    localparam int CFG_Y_BASE = 4;

    // Falloff: largest t with t*t*d2 <= (9216/8)^2, capped at 255
    localparam int FALL_W      = 8;
    localparam int FALLOFF_NUM = 1327104;
    localparam int NUM_W       = 21;

    // Channel sum: up to four circles at weight 2 of 255
    localparam int SUM_W = 11;
    localparam logic [SUM_W-1:0] CHAN_MAX = 11'd255;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [1:0]        weight_t;

    localparam weight_t WEIGHT_R [CIRCLE_MAX] = '{2'd2, 2'd1, 2'd1, 2'd2};
    localparam weight_t WEIGHT_G [CIRCLE_MAX] = '{2'd1, 2'd2, 2'd1, 2'd2};
    localparam weight_t WEIGHT_B [CIRCLE_MAX] = '{2'd1, 2'd1, 2'd2, 2'd1};

    localparam logic [CX_W-1:0] RESET_X [CIRCLE_MAX] = '{10'd55, 10'd165, 10'd55, 10'd165};
    localparam logic [CY_W-1:0] RESET_Y [CIRCLE_MAX] = '{9'd44, 9'd132, 9'd44, 9'd132};

endpackage

`default_nettype wire

// ===== rtl/mbps_distance.sv =====
// Per-circle distance stages: saturated |dx|, |dy|, then squared distance.
`default_nettype none

module mbps_distance #(
    parameter int TABLE_ROWS    = 176,
    parameter int TABLE_COLUMNS = 256,
    parameter int D2W           = 17
) (
    input  wire logic                          clk,
    input  wire logic [1:0]                    en,
    input  wire logic [mbps_pkg::CX_W-1:0]     cx,
    input  wire logic [mbps_pkg::CY_W-1:0]     cy,
    input  wire logic [mbps_pkg::PIX_W-1:0]    px,
    input  wire logic [mbps_pkg::PIX_W-1:0]    py,
    output logic      [D2W-1:0]                d2
);
    import mbps_pkg::*;

    localparam int DXW   = $clog2(TABLE_COLUMNS);
    localparam int DYW   = $clog2(TABLE_ROWS);
    localparam int DIF_W = 12;

    logic [DIF_W-1:0] dif_x;
    logic [DIF_W-1:0] dif_y;
    logic [DIF_W-1:0] abs_x;
    logic [DIF_W-1:0] abs_y;
    logic [DXW-1:0]   dx_next;
    logic [DYW-1:0]   dy_next;
    logic [DXW-1:0]   dx_reg;
    logic [DYW-1:0]   dy_reg;
    logic [2*DXW-1:0] sq_x;
    logic [2*DYW-1:0] sq_y;
    logic [D2W-1:0]   d2_next;
    logic [D2W-1:0]   d2_reg;

    always_comb
    begin
        dif_x = {{(DIF_W-CX_W){cx[CX_W-1]}}, cx} - {{(DIF_W-PIX_W){1'b0}}, px};
        dif_y = {{(DIF_W-CY_W){cy[CY_W-1]}}, cy} - {{(DIF_W-PIX_W){1'b0}}, py};
        abs_x = dif_x[DIF_W-1] ? (~dif_x + 1'b1) : dif_x;
        abs_y = dif_y[DIF_W-1] ? (~dif_y + 1'b1) : dif_y;
        // beyond the table edge the lookup sticks to the last column/row
        dx_next = (abs_x > DIF_W'(TABLE_COLUMNS-1)) ? DXW'(TABLE_COLUMNS-1) : abs_x[DXW-1:0];
        dy_next = (abs_y > DIF_W'(TABLE_ROWS-1))    ? DYW'(TABLE_ROWS-1)    : abs_y[DYW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    always_comb
    begin
        sq_x    = dx_reg * dx_reg;
        sq_y    = dy_reg * dy_reg;
        d2_next = D2W'(sq_x) + D2W'(sq_y);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            d2_reg <= d2_next;
        end
    end

    assign d2 = d2_reg;

endmodule

`default_nettype wire

// ===== rtl/mbps_falloff.sv =====
// Falloff pipeline: one result bit per stage, t*t*d2 tracked by shifts and adds.
`default_nettype none

module mbps_falloff #(
    parameter int D2W = 17
) (
    input  wire logic                         clk,
    input  wire logic [mbps_pkg::FALL_W-1:0]  en,
    input  wire logic [D2W-1:0]               d2,
    output logic      [mbps_pkg::FALL_W-1:0]  falloff
);
    import mbps_pkg::*;

    localparam int STEPS = FALL_W;
    localparam int QW    = D2W + FALL_W;
    localparam int CW    = D2W + 2*FALL_W + 1;

    // p = t*t*d2, q = t*d2 for the bits of t settled so far
    logic [NUM_W-1:0]  p_reg  [STEPS-1];
    logic [QW-1:0]     q_reg  [STEPS-1];
    logic [D2W-1:0]    d2_reg [STEPS-1];
    logic [FALL_W-1:0] t_reg  [STEPS];

    for (genvar s = 0; s < STEPS; s++)
    begin : g_step
        localparam int K = STEPS - 1 - s;

        logic [NUM_W-1:0]  p_prev;
        logic [QW-1:0]     q_prev;
        logic [D2W-1:0]    d2_prev;
        logic [FALL_W-1:0] t_prev;
        logic [CW-1:0]     cand;
        logic              take;
        logic [FALL_W-1:0] t_next;

        if (s == 0)
        begin : g_first
            assign p_prev  = '0;
            assign q_prev  = '0;
            assign d2_prev = d2;
            assign t_prev  = '0;
        end
        else
        begin : g_chain
            assign p_prev  = p_reg[s-1];
            assign q_prev  = q_reg[s-1];
            assign d2_prev = d2_reg[s-1];
            assign t_prev  = t_reg[s-1];
        end

        // (t + 2^K)^2 * d2 = p + q*2^(K+1) + d2*2^(2K)
        always_comb
        begin
            cand = CW'(p_prev) + (CW'(q_prev) << (K+1)) + (CW'(d2_prev) << (2*K));
            take = (cand <= CW'(FALLOFF_NUM));
            t_next    = t_prev;
            t_next[K] = take;
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                t_reg[s] <= t_next;
            end
        end

        if (s < STEPS-1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    p_reg[s]  <= take ? cand[NUM_W-1:0] : p_prev;
                    q_reg[s]  <= take ? (q_prev + (QW'(d2_prev) << K)) : q_prev;
                    d2_reg[s] <= d2_prev;
                end
            end
        end
    end

    assign falloff = t_reg[STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/mbps_mix.sv =====
// Output stage: weighted channel sums, clamp, RGB565 packing register.
`default_nettype none

module mbps_mix #(
    parameter int CIRCLE_COUNT = 4
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [mbps_pkg::FALL_W-1:0] falloff [CIRCLE_COUNT],
    output logic      [mbps_pkg::RGB_W-1:0]  rgb565
);
    import mbps_pkg::*;

    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;
    chan_t            red;
    chan_t            green;
    chan_t            blue;
    logic [RGB_W-1:0] rgb_next;
    logic [RGB_W-1:0] rgb_reg;

    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int i = 0; i < CIRCLE_COUNT; i++)
        begin
            sum_r = sum_r + SUM_W'(falloff[i]) * SUM_W'(WEIGHT_R[i]);
            sum_g = sum_g + SUM_W'(falloff[i]) * SUM_W'(WEIGHT_G[i]);
            sum_b = sum_b + SUM_W'(falloff[i]) * SUM_W'(WEIGHT_B[i]);
        end
        red   = (sum_r > CHAN_MAX) ? chan_t'(CHAN_MAX) : sum_r[CHAN_W-1:0];
        green = (sum_g > CHAN_MAX) ? chan_t'(CHAN_MAX) : sum_g[CHAN_W-1:0];
        blue  = (sum_b > CHAN_MAX) ? chan_t'(CHAN_MAX) : sum_b[CHAN_W-1:0];
        rgb_next = {red[7:3], green[7:2], blue[7:3]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb565 = rgb_reg;

endmodule

`default_nettype wire

// ===== rtl/metaball_pixel_shader.sv =====
// Top level of the metaball pixel shader: circle registers, pipeline control, lanes.
`default_nettype none

// Shades one pixel per clock while the output accepts data: each pixel
// coordinate transaction on the input stream yields one RGB565 transaction on
// the output stream after two distance stages, eight falloff stages resolving
// one bit each and one mix stage. Every stage has its own valid bit, so a new
// pixel may enter every cycle and output back-pressure only halts stages that
// hold data. The four circle centres are written through the cfg port (index
// 0..3 = x, 4..7 = y) and should only change while no pixels are in flight.

module metaball_pixel_shader #(
    parameter int CIRCLE_COUNT  = 4,
    parameter int TABLE_ROWS    = 176,
    parameter int TABLE_COLUMNS = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [2*mbps_pkg::PIX_W-1:0]       s_axis_tdata,   // pixel_x, pixel_y
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic      [mbps_pkg::RGB_W-1:0]         m_axis_tdata,   // pixel_rgb565
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [mbps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mbps_pkg::CX_W-1:0]          cfg_data
);
    import mbps_pkg::*;

    localparam int DXW    = $clog2(TABLE_COLUMNS);
    localparam int DYW    = $clog2(TABLE_ROWS);
    localparam int DMAX   = (DXW > DYW) ? DXW : DYW;
    localparam int D2W    = 2*DMAX + 1;
    localparam int NSTAGE = 2 + FALL_W + 1;

    logic [CX_W-1:0]   cx_reg [CIRCLE_COUNT];
    logic [CY_W-1:0]   cy_reg [CIRCLE_COUNT];
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE:0]   rdy;
    logic [PIX_W-1:0]  px;
    logic [PIX_W-1:0]  py;
    logic [FALL_W-1:0] falloff [CIRCLE_COUNT];

    assign px        = s_axis_tdata[PIX_W-1:0];
    assign py        = s_axis_tdata[2*PIX_W-1:PIX_W];
    assign cfg_ready = 1'b1;

    // Circle centre registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CIRCLE_COUNT; i++)
            begin
                cx_reg[i] <= RESET_X[i];
                cy_reg[i] <= RESET_Y[i];
            end
        end
        else if (cfg_valid)
        begin
            for (int i = 0; i < CIRCLE_COUNT; i++)
            begin
                if (cfg_index == CFG_IDX_W'(CFG_X_BASE + i))
                begin
                    cx_reg[i] <= cfg_data;
                end
                if (cfg_index == CFG_IDX_W'(CFG_Y_BASE + i))
                begin
                    cy_reg[i] <= cfg_data[CY_W-1:0];
                end
            end
        end
    end

    // A stage may load when it is empty or its contents move on
    always_comb
    begin
        rdy[NSTAGE] = m_axis_tready;
        for (int i = NSTAGE-1; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        for (int i = 0; i < NSTAGE; i++)
        begin
            if (rdy[i])
            begin
                valid_next[i] = (i == 0) ? s_axis_tvalid : valid_reg[(i == 0) ? 0 : i-1];
            end
            else
            begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    for (genvar c = 0; c < CIRCLE_COUNT; c++)
    begin : g_lane
        logic [D2W-1:0] d2;

        mbps_distance #(
            .TABLE_ROWS    (TABLE_ROWS),
            .TABLE_COLUMNS (TABLE_COLUMNS),
            .D2W           (D2W)
        ) u_distance (
            .clk (clk),
            .en  (rdy[1:0]),
            .cx  (cx_reg[c]),
            .cy  (cy_reg[c]),
            .px  (px),
            .py  (py),
            .d2  (d2)
        );

        mbps_falloff #(
            .D2W (D2W)
        ) u_falloff (
            .clk     (clk),
            .en      (rdy[FALL_W+1:2]),
            .d2      (d2),
            .falloff (falloff[c])
        );
    end

    mbps_mix #(
        .CIRCLE_COUNT (CIRCLE_COUNT)
    ) u_mix (
        .clk     (clk),
        .en      (rdy[NSTAGE-1]),
        .falloff (falloff),
        .rgb565  (m_axis_tdata)
    );

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = valid_reg[NSTAGE-1];

endmodule

`default_nettype wire
